### hdl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, codes and types of the frame bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fba_pkg;

    // Default capacity of the status map, in frames
    localparam int MAX_FRAMES_DEF = 8192;

    // Field widths
    localparam int FRAME_W    = 20;
    localparam int POOL_W     = 14;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Wide arithmetic on frame numbers keeps one carry bit
    localparam int AW = FRAME_W + 1;

    // Map row layout: 64 frames per row, two status bits per frame
    localparam int FPR      = 64;
    localparam int FSEL_W   = $clog2(FPR);
    localparam int ROW_BITS = 2 * FPR;

    // Status bit positions inside one frame's pair
    localparam int FLAG_ALLOC_BIT = 0;
    localparam int FLAG_INACC_BIT = 1;

    // Request functions
    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_MARK    = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_INACC = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVE = 2'd2;

    // Configuration reset values
    localparam logic [FRAME_W-1:0] BASE_RST    = 20'd0;
    localparam logic [POOL_W-1:0]  POOL_RST    = 14'd512;
    localparam logic               RESERVE_RST = 1'b1;

    // Configuration seen by the controller
    typedef struct packed {
        logic [FRAME_W-1:0] base;
        logic [POOL_W-1:0]  pool;
        logic               reserve;
    } t_cfg;

endpackage

`default_nettype wire

### hdl/frame_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top
// First-fit physical frame allocator over a two-bit-per-frame status map.
//
//   channel   signals                                   accepted when
//   request   i_start, o_busy, i_func, i_frame,         i_start && !o_busy
//             i_run_length
//   result    o_done, o_granted_frame, o_status         o_done (one cycle)
//   config    i_cfg_valid, o_cfg_ready, i_cfg_index,    i_cfg_valid && o_cfg_ready
//             i_cfg_data
//
// One request at a time; one 64-frame row per cycle through a registered read.
// An allocate scans at most ceil(pool/64) rows, and a mark rewrites each row the run
// touches; an empty pool, an out-of-range release or a run that misses the pool
// answers without touching the map.
// Reset zeros the map at once through per-row valid bits; no clearing pass.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bitmap_allocator_top
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output      logic                  o_busy,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [FRAME_W-1:0]    i_frame,
    input  wire logic [POOL_W-1:0]     i_run_length,
    output      logic                  o_done,
    output      logic [FRAME_W-1:0]    o_granted_frame,
    output      logic [STAT_W-1:0]     o_status,
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROWS = (MAX_FRAMES + FPR - 1) / FPR;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [FRAME_W-1:0]  r_base;
    logic [POOL_W-1:0]   r_pool;
    logic                r_reserve;
    t_cfg                w_cfg;

    logic                w_rd_en;
    logic [RW-1:0]       w_rd_row;
    logic [ROW_BITS-1:0] w_rd_data;
    logic                w_wr_en;
    logic [RW-1:0]       w_wr_row;
    logic [ROW_BITS-1:0] w_wr_data;
    logic                w_clr;

    // Configuration writes; unknown indexes drop
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= BASE_RST;
            r_pool    <= POOL_RST;
            r_reserve <= RESERVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BASE:    r_base    <= i_cfg_data[FRAME_W-1:0];
                CFG_POOL:    r_pool    <= i_cfg_data[POOL_W-1:0];
                CFG_RESERVE: r_reserve <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg = '{base: r_base, pool: r_pool, reserve: r_reserve};

    fba_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .ROWS       (ROWS),
        .RW         (RW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_func          (i_func),
        .i_frame         (i_frame),
        .i_run_length    (i_run_length),
        .i_cfg           (w_cfg),
        .o_done          (o_done),
        .o_granted_frame (o_granted_frame),
        .o_status        (o_status),
        .o_rd_en         (w_rd_en),
        .o_rd_row        (w_rd_row),
        .i_rd_data       (w_rd_data),
        .o_wr_en         (w_wr_en),
        .o_wr_row        (w_wr_row),
        .o_wr_data       (w_wr_data),
        .o_clr           (w_clr)
    );

    fba_map_mem #(
        .ROWS (ROWS),
        .RW   (RW)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_row  (w_rd_row),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_row  (w_wr_row),
        .i_wr_data (w_wr_data),
        .i_clr     (w_clr)
    );

endmodule

`default_nettype wire

### hdl/fba_map_mem.sv
// ----------------------------------------------------------------------------
// fba_map_mem
// Frame status map: one row of 64 frame pairs per entry, one write and one
// registered read port, plus a valid bit per row so that a cleared row reads
// as zero without a sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_map_mem
    import fba_pkg::*;
#(
    parameter int ROWS = 1,
    parameter int RW   = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_rd_en,
    input  wire logic [RW-1:0]       i_rd_row,
    output      logic [ROW_BITS-1:0] o_rd_data,
    input  wire logic                i_wr_en,
    input  wire logic [RW-1:0]       i_wr_row,
    input  wire logic [ROW_BITS-1:0] i_wr_data,
    input  wire logic                i_clr
);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROWS-1:0]     r_vld;
    logic [ROW_BITS-1:0] r_rd_data;
    logic                r_rd_vld;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_row] <= i_wr_data;
        end
    end

    // Row valid bits: clear drops all, a write validates its row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_clr) begin
                r_vld <= '0;
            end
            if (i_wr_en) begin
                r_vld[i_wr_row] <= 1'b1;
            end
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_row];
            r_rd_vld  <= r_vld[i_rd_row];
        end
    end

    // Unwritten rows read as all frames free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

### hdl/fba_ctrl.sv
// ----------------------------------------------------------------------------
// fba_ctrl
// Request sequencer: range checks, first-fit row scan, run marking and
// release, all as read-modify-write of map rows.
// ----------------------------------------------------------------------------
`default_nettype none

module fba_ctrl
    import fba_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int ROWS       = (MAX_FRAMES + FPR - 1) / FPR,
    parameter int RW         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output      logic                o_busy,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [FRAME_W-1:0]  i_frame,
    input  wire logic [POOL_W-1:0]   i_run_length,
    input  wire t_cfg                i_cfg,
    output      logic                o_done,
    output      logic [FRAME_W-1:0]  o_granted_frame,
    output      logic [STAT_W-1:0]   o_status,
    output      logic                o_rd_en,
    output      logic [RW-1:0]       o_rd_row,
    input  wire logic [ROW_BITS-1:0] i_rd_data,
    output      logic                o_wr_en,
    output      logic [RW-1:0]       o_wr_row,
    output      logic [ROW_BITS-1:0] o_wr_data,
    output      logic                o_clr
);

    localparam int XW = RW + FSEL_W;
    localparam int EW = XW + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_MSET   = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_MARK   = 8'b0001_0000,
        S_RREAD  = 8'b0010_0000,
        S_RWRITE = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func;
    logic [FRAME_W-1:0]  r_frame;
    logic [POOL_W-1:0]   r_run;
    logic [EW-1:0]       r_n;
    logic [AW-1:0]       r_lo, r_hi;
    logic [XW-1:0]       r_off;
    logic [RW-1:0]       r_stop_row;
    logic [FSEL_W-1:0]   r_stop_sel;
    logic [RW-1:0]       r_rd_row;
    logic                r_rd_more;
    logic                r_chk_v;
    logic [RW-1:0]       r_chk_row;
    logic                r_grant;
    logic [STAT_W-1:0]   r_res_stat;
    logic                r_done;
    logic [FRAME_W-1:0]  r_granted;
    logic [STAT_W-1:0]   r_status;

    logic [EW-1:0]       w_pool_n;
    logic [EW-1:0]       w_n_m1;
    logic [AW-1:0]       w_base, w_frame_x, w_diff;
    logic                w_rel_out;
    logic [AW-1:0]       w_end_f, w_end_p, w_lo, w_hi;
    logic [AW-1:0]       w_lo_off, w_hi_off;
    logic [XW-1:0]       w_lo_x, w_hi_x;
    logic [ROW_BITS-1:0] w_row;
    logic                w_last;
    logic [FPR-1:0]      w_free;
    logic                w_hit;
    logic [FSEL_W-1:0]   w_sel;
    logic [ROW_BITS-1:0] w_alloc_row;
    logic [FSEL_W-1:0]   w_ms, w_me;
    logic [ROW_BITS-1:0] w_mark_row;
    logic [FSEL_W-1:0]   w_rsel;
    logic                w_rel_inacc;
    logic [ROW_BITS-1:0] w_rel_row;
    logic                w_issue;

    // Pool size clamped to map capacity
    assign w_pool_n = (AW'(i_cfg.pool) > AW'(MAX_FRAMES)) ? EW'(MAX_FRAMES)
                                                          : EW'(i_cfg.pool);
    assign w_n_m1   = r_n - EW'(1);

    // Release range check
    assign w_base    = {1'b0, i_cfg.base};
    assign w_frame_x = {1'b0, r_frame};
    assign w_diff    = w_frame_x - w_base;
    assign w_rel_out = w_diff[AW-1] || (w_diff >= AW'(r_n));

    // Run bounds clipped to the pool
    assign w_end_f  = w_frame_x + AW'(r_run);
    assign w_end_p  = w_base + AW'(r_n);
    assign w_lo     = (w_frame_x < w_base) ? w_base : w_frame_x;
    assign w_hi     = (w_end_f > w_end_p) ? w_end_p : w_end_f;
    assign w_lo_off = r_lo - w_base;
    assign w_hi_off = r_hi - w_base - AW'(1);
    assign w_lo_x   = XW'(w_lo_off);
    assign w_hi_x   = XW'(w_hi_off);

    assign w_row  = i_rd_data;
    assign w_last = (r_chk_row == r_stop_row);

    // Free frames of the returned row, limited to the pool in the last row
    always_comb begin
        for (int j = 0; j < FPR; j++) begin
            w_free[j] = !w_row[2*j + FLAG_ALLOC_BIT] && !w_row[2*j + FLAG_INACC_BIT]
                        && (!w_last || (FSEL_W'(j) <= r_stop_sel));
        end
    end

    // Lowest free frame
    always_comb begin
        w_sel = '0;
        for (int j = FPR - 1; j >= 0; j--) begin
            if (w_free[j]) begin
                w_sel = FSEL_W'(j);
            end
        end
    end
    assign w_hit = |w_free;

    // Row with the chosen frame taken
    always_comb begin
        w_alloc_row = w_row;
        w_alloc_row[{w_sel, 1'b0} +: 2] = 2'b01;
    end

    // Row with the run's frames flagged inaccessible
    assign w_ms = (r_chk_row == r_off[XW-1:FSEL_W]) ? r_off[FSEL_W-1:0] : '0;
    assign w_me = w_last ? r_stop_sel : '1;
    always_comb begin
        w_mark_row = w_row;
        for (int j = 0; j < FPR; j++) begin
            if ((FSEL_W'(j) >= w_ms) && (FSEL_W'(j) <= w_me)) begin
                w_mark_row[2*j + FLAG_INACC_BIT] = 1'b1;
            end
        end
    end

    // Row with the released frame freed
    assign w_rsel      = r_off[FSEL_W-1:0];
    assign w_rel_inacc = w_row[{w_rsel, 1'b1}];
    always_comb begin
        w_rel_row = w_row;
        w_rel_row[{w_rsel, 1'b0} +: 2] = 2'b00;
    end

    // Map read port
    assign w_issue  = ((r_state == S_SCAN) || (r_state == S_MARK)) && r_rd_more;
    assign o_rd_en  = w_issue || (r_state == S_RREAD);
    assign o_rd_row = (r_state == S_RREAD) ? r_off[XW-1:FSEL_W] : r_rd_row;

    // Map write port and clear
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_row  = r_chk_row;
        o_wr_data = w_alloc_row;
        o_clr     = 1'b0;
        unique case (r_state)
            S_PREP: begin
                if (r_func == FN_CLEAR) begin
                    o_clr     = 1'b1;
                    o_wr_en   = i_cfg.reserve && (r_n != '0);
                    o_wr_row  = '0;
                    o_wr_data = ROW_BITS'(1) << FLAG_ALLOC_BIT;
                end
            end
            S_SCAN: begin
                o_wr_en = r_chk_v && w_hit;
            end
            S_MARK: begin
                o_wr_en   = r_chk_v;
                o_wr_data = w_mark_row;
            end
            S_RWRITE: begin
                o_wr_en   = !w_rel_inacc;
                o_wr_row  = r_off[XW-1:FSEL_W];
                o_wr_data = w_rel_row;
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_PREP;
            end
            S_PREP: begin
                unique case (r_func)
                    FN_ALLOC:   n_state = (r_n == '0) ? S_RESP : S_SCAN;
                    FN_RELEASE: n_state = w_rel_out ? S_RESP : S_RREAD;
                    FN_MARK:    n_state = S_MSET;
                    FN_CLEAR:   n_state = S_RESP;
                    default:    n_state = S_RESP;
                endcase
            end
            S_MSET: begin
                n_state = (r_lo >= r_hi) ? S_RESP : S_MARK;
            end
            S_SCAN: begin
                if (r_chk_v && (w_hit || w_last)) n_state = S_RESP;
            end
            S_MARK: begin
                if (r_chk_v && w_last) n_state = S_RESP;
            end
            S_RREAD:  n_state = S_RWRITE;
            S_RWRITE: n_state = S_RESP;
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_rd_more <= 1'b0;
            r_chk_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_RESP);
            // load the row pipeline on entry, advance it while scanning
            if ((r_state == S_PREP) || (r_state == S_MSET)) begin
                r_rd_more <= 1'b1;
                r_chk_v   <= 1'b0;
            end else begin
                r_chk_v <= w_issue;
                if (w_issue && (r_rd_row == r_stop_row)) begin
                    r_rd_more <= 1'b0;
                end
            end
        end
    end

    // Request payload and working registers
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_row <= r_rd_row + RW'(1);
        end
        r_chk_row <= r_rd_row;
        unique case (r_state)
            S_IDLE: begin
                r_func     <= i_func;
                r_frame    <= i_frame;
                r_run      <= i_run_length;
                r_n        <= w_pool_n;
                r_grant    <= 1'b0;
                r_res_stat <= ST_OK;
            end
            S_PREP: begin
                unique case (r_func)
                    FN_ALLOC: begin
                        r_res_stat <= ST_FULL;
                        r_stop_row <= w_n_m1[XW-1:FSEL_W];
                        r_stop_sel <= w_n_m1[FSEL_W-1:0];
                        r_rd_row   <= '0;
                    end
                    FN_RELEASE: begin
                        r_res_stat <= w_rel_out ? ST_RANGE : ST_OK;
                        r_off      <= XW'(w_diff);
                    end
                    FN_MARK: begin
                        r_lo <= w_lo;
                        r_hi <= w_hi;
                    end
                    default: begin
                    end
                endcase
            end
            S_MSET: begin
                r_off      <= w_lo_x;
                r_stop_row <= w_hi_x[XW-1:FSEL_W];
                r_stop_sel <= w_hi_x[FSEL_W-1:0];
                r_rd_row   <= w_lo_x[XW-1:FSEL_W];
            end
            S_SCAN: begin
                if (r_chk_v && w_hit) begin
                    r_off      <= {r_chk_row, w_sel};
                    r_grant    <= 1'b1;
                    r_res_stat <= ST_OK;
                end
            end
            S_RWRITE: begin
                r_res_stat <= w_rel_inacc ? ST_INACC : ST_OK;
            end
            S_RESP: begin
                r_granted <= r_grant ? FRAME_W'(w_base + AW'(r_off)) : '0;
                r_status  <= r_res_stat;
            end
            default: begin
            end
        endcase
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_granted_frame = r_granted;
    assign o_status        = r_status;

endmodule

`default_nettype wire
